FILE: src/bae_pkg.sv
// Shared types and constants for the binary arithmetic encoder.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package bae_pkg;

   // Command codes carried in a request
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Interval constants
   localparam logic [31:0] LOW_RESET  = 32'h0000_0000;
   localparam logic [31:0] HIGH_RESET = 32'hffff_ffff;
   localparam logic [7:0]  FILL_BYTE  = 8'hff;

   // Bytes emitted by one encode request at most
   localparam int MAX_BYTES = 4;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        command;
      logic        bit_value;
      logic [15:0] prob_one;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Classified job handed from the front to the back
   typedef struct packed {
      logic        is_finish;
      logic        bit_value;
      logic [15:0] prob_one;
   } job_type;

endpackage

FILE: src/binary_arithmetic_encoder.sv
// Binary arithmetic encoder, top level: front register, job queue, back end.
// Flow: an encode request passes the front register and the job queue before the back
// end takes it; the back end then steps through ST_MUL, ST_MID and ST_EMIT and presents
// each byte through its output register, and takes a finish through ST_FLUSH. It takes
// no new job until it is back in ST_IDLE.
// Reset: synchronous; empties the queue and restores the interval to full range.
`timescale 1ns / 1ps

module binary_arithmetic_encoder #(
   parameter int QUEUE_DEPTH = bae_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  bae_pkg::req_type req_data,
   // coded byte channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bae_pkg::rsp_type rsp_data
);

   // Front to queue
   logic             front_valid;
   logic             front_ready;
   bae_pkg::job_type front_job;

   // Queue to back end
   logic             back_valid;
   logic             back_ready;
   bae_pkg::job_type back_job;

   // Accept and classify each request; hold it until the queue has room
   bae_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_data  (front_job)
   );

   // Decouple the front from the back so each side stalls on its own
   bae_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_job)
   );

   // Split the interval, renormalise and present coded bytes through a
   // registered output stage
   bae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/bae_front.sv
// Front end: accepts requests, classifies them into jobs and holds one job
// until the queue takes it. Depends on bae_pkg.
`timescale 1ns / 1ps

module bae_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bae_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_ready,
   output bae_pkg::job_type job_data
);

   logic             hold_valid_ff, hold_valid_in;
   bae_pkg::job_type hold_ff, hold_in;
   logic             push;
   logic             take;

   assign push      = hold_valid_ff && job_ready;
   assign req_ready = !hold_valid_ff || job_ready;
   assign take      = req_valid && req_ready;
   assign job_valid = hold_valid_ff;
   assign job_data  = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_valid_in     = 1'b1;
         hold_in.is_finish = (req_data.command == bae_pkg::CMD_FINISH);
         hold_in.bit_value = req_data.bit_value;
         // drop the probability on a finish, it plays no part
         hold_in.prob_one  = (req_data.command == bae_pkg::CMD_FINISH) ? 16'h0000
                                                                        : req_data.prob_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

FILE: src/bae_queue.sv
// Short job queue between the front and the back of the encoder.
// Depends on bae_pkg for the job type.
`timescale 1ns / 1ps

module bae_queue #(
   parameter int DEPTH = bae_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bae_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output bae_pkg::job_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bae_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: src/bae_back.sv
// Back end: interval arithmetic, byte renormalisation and the output register.
// Depends on bae_pkg.
`timescale 1ns / 1ps

module bae_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  bae_pkg::job_type job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bae_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MID,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   localparam int NUM_W = $clog2(bae_pkg::MAX_BYTES);

   state_type        state_ff, state_in;
   logic [31:0]      low_ff, low_in;
   logic [31:0]      high_ff, high_in;
   logic [31:0]      span_ff, span_in;
   logic             bit_ff, bit_in;
   logic [15:0]      prob_ff, prob_in;
   logic [31:0]      hi_prod_ff, hi_prod_in;
   logic [31:0]      lo_prod_ff, lo_prod_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bae_pkg::rsp_type rsp_ff, rsp_in;

   logic        slot_free;
   logic [31:0] mid;
   logic [31:0] low_shift;
   logic [31:0] high_shift;
   logic        agree;
   logic        agree_next;
   logic        final_byte;

   assign job_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   assign mid        = low_ff + hi_prod_ff + {16'h0000, lo_prod_ff[31:16]};
   assign low_shift  = {low_ff[23:0], 8'h00};
   assign high_shift = {high_ff[23:0], bae_pkg::FILL_BYTE};
   assign agree      = (low_ff[31:24] == high_ff[31:24]);
   assign agree_next = (low_shift[31:24] == high_shift[31:24]);
   assign final_byte = !agree_next || (num_ff == NUM_W'(bae_pkg::MAX_BYTES - 1));

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      span_in      = span_ff;
      bit_in       = bit_ff;
      prob_in      = prob_ff;
      hi_prod_in   = hi_prod_ff;
      lo_prod_in   = lo_prod_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               bit_in  = job_data.bit_value;
               prob_in = job_data.prob_one;
               span_in = high_ff - low_ff;
               state_in = job_data.is_finish ? ST_FLUSH : ST_MUL;
            end
         end
         ST_MUL: begin
            hi_prod_in = span_ff[31:16] * prob_ff;
            lo_prod_in = span_ff[15:0] * prob_ff;
            state_in   = ST_MID;
         end
         ST_MID: begin
            // a one keeps the lower part, a zero the upper part
            if (bit_ff) begin
               high_in = mid;
            end else begin
               low_in = mid + 32'd1;
            end
            num_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!agree) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.out_byte = high_ff[31:24];
               rsp_in.last     = final_byte;
               low_in          = low_shift;
               high_in         = high_shift;
               num_in          = num_ff + 1'b1;
               if (final_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.out_byte = high_ff[31:24];
               rsp_in.last     = 1'b1;
               low_in          = bae_pkg::LOW_RESET;
               high_in         = bae_pkg::HIGH_RESET;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= bae_pkg::LOW_RESET;
         high_ff      <= bae_pkg::HIGH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      span_ff    <= span_in;
      bit_ff     <= bit_in;
      prob_ff    <= prob_in;
      hi_prod_ff <= hi_prod_in;
      lo_prod_ff <= lo_prod_in;
      num_ff     <= num_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the carry-less binary arithmetic encoder: directed and random requests
// predicted by a local interval model and checked byte by byte. Depends on src/bae_pkg.sv and
// src/binary_arithmetic_encoder.sv, and through it on the front, queue and back files.
`timescale 1ns / 1ps

module testbench;

   // Cycles with no transfer on either channel before the run is abandoned
   localparam int STALL_LIMIT     = 2000;
   // Cycles the byte receiver holds off once to back the encoder up
   localparam int HOLD_OFF_CYCLES = 120;
   // Cycles to idle after the last byte, to catch anything extra
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_REQUESTS = 236;

   // Predictor of the coded byte stream and store of the bytes still owed by the encoder
   class coded_byte_board;
      logic [31:0]      interval_low;
      logic [31:0]      interval_high;
      bae_pkg::rsp_type pending_bytes[$];
      int               failures;
      int               bytes_checked;

      function new();
         interval_low  = bae_pkg::LOW_RESET;
         interval_high = bae_pkg::HIGH_RESET;
         failures      = 0;
         bytes_checked = 0;
      endfunction

      task report_mismatch(string what, int got, int want);
         if (failures < 40)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
         failures++;
      endtask

      // Append one byte to the list still owed by the encoder
      function void owe_byte(bae_pkg::rsp_type b);
         pending_bytes = {pending_bytes, b};
      endfunction

      // Advance the interval for one accepted request and queue the bytes it must produce
      function void note_request(bae_pkg::req_type r);
         logic [31:0]      span;
         logic [31:0]      upper_part;
         logic [31:0]      lower_part;
         logic [31:0]      split;
         int               emitted;
         bae_pkg::rsp_type b;
         if (r.command == bae_pkg::CMD_FINISH) begin
            b.out_byte = interval_high[31:24];
            b.last     = 1'b1;
            owe_byte(b);
            interval_low  = bae_pkg::LOW_RESET;
            interval_high = bae_pkg::HIGH_RESET;
            return;
         end
         span       = interval_high - interval_low;
         upper_part = (span >> 16) * {16'h0000, r.prob_one};
         lower_part = ({16'h0000, span[15:0]} * {16'h0000, r.prob_one}) >> 16;
         split      = interval_low + upper_part + lower_part;
         if (r.bit_value)
            interval_high = split;
         else
            interval_low = split + 32'd1;
         emitted = 0;
         while (emitted < bae_pkg::MAX_BYTES && interval_low[31:24] == interval_high[31:24]) begin
            b.out_byte    = interval_high[31:24];
            interval_low  = interval_low << 8;
            interval_high = {interval_high[23:0], bae_pkg::FILL_BYTE};
            emitted++;
            b.last = (emitted == bae_pkg::MAX_BYTES) ||
                     (interval_low[31:24] != interval_high[31:24]);
            owe_byte(b);
         end
      endfunction

      task check_byte(bae_pkg::rsp_type got);
         bae_pkg::rsp_type want;
         if (pending_bytes.size() == 0) begin
            report_mismatch("byte with none owed", got.out_byte, 0);
            return;
         end
         want = pending_bytes.pop_front();
         bytes_checked++;
         if (got.out_byte != want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
         if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bae_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bae_pkg::rsp_type rsp_data;

   coded_byte_board board = new();
   int              requests_accepted = 0;
   int              finishes_accepted = 0;
   int              stall_cycles      = 0;
   bit              held_off          = 1'b0;

   binary_arithmetic_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Idle length for either side: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 2);
      else if (r < 97)
         return $urandom_range(3, 8);
      else
         return $urandom_range(15, 40);
   endfunction

   // Probabilities: extremes, heavily skewed (long byte bursts) and uniform
   function automatic logic [15:0] pick_probability();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20)
         return $urandom_range(0, 3) < 2 ? 16'($urandom_range(0, 2))
                                         : 16'($urandom_range(65533, 65535));
      else if (r < 55)
         return $urandom_range(0, 1) ? 16'($urandom_range(0, 2047))
                                     : 16'($urandom_range(63488, 65535));
      else
         return 16'($urandom_range(0, 65535));
   endfunction

   function automatic bae_pkg::req_type make_request(logic command, logic bit_value,
                                                     logic [15:0] prob_one);
      bae_pkg::req_type r;
      r.command   = command;
      r.bit_value = bit_value;
      r.prob_one  = prob_one;
      return r;
   endfunction

   // Offer one request from a falling edge; return at the falling edge after its acceptance.
   // Valid is only lowered for a gap, never dropped and raised within the same edge.
   task automatic send_request(bae_pkg::req_type r, bit allow_gap);
      int gap;
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      board.note_request(r);
      requests_accepted++;
      if (r.command == bae_pkg::CMD_FINISH)
         finishes_accepted++;
      @(negedge clock);
   endtask

   // Byte receiver: random hold-offs, one long hold to fill the encoder, and a stretch
   // with ready held high throughout
   initial begin : byte_receiver
      int hold;
      int longest_hold;
      hold         = 0;
      longest_hold = 0;
      rsp_ready    = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!held_off && requests_accepted >= 60) begin
            held_off = 1'b1;
            hold     = HOLD_OFF_CYCLES;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            board.check_byte(rsp_data);
            if (board.bytes_checked >= 150 && board.bytes_checked < 230)
               hold = 0;
            else
               hold = pick_gap();
         end
         @(negedge clock);
      end
   end

   // Watchdog: abandon the run when neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d bytes still owed", $realtime,
                  stall_cycles, board.pending_bytes.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : request_sender
      bae_pkg::req_type directed[$];
      logic             command;
      logic             bit_value;
      logic [15:0]      prob_one;
      // Hold every input at a known value through reset
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: finish on a fresh stream, zero probability with bit one (single-value
      // interval, four bytes), bit zero with full probability (wrapping bounds), ignored
      // fields on finish, and back-to-back finishes
      directed = {directed, make_request(bae_pkg::CMD_FINISH, 1'b0, 16'h0000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'h0000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'h0000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'h0001)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'h0001)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'h8000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'h8000)};
      directed = {directed, make_request(bae_pkg::CMD_FINISH, 1'b1, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'h0000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'hffff)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'hfffe)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'h0000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'h7fff)};
      directed = {directed, make_request(bae_pkg::CMD_FINISH, 1'b0, 16'h1234)};
      directed = {directed, make_request(bae_pkg::CMD_FINISH, 1'b1, 16'h0000)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b0, 16'h5555)};
      directed = {directed, make_request(bae_pkg::CMD_ENCODE, 1'b1, 16'haaaa)};
      directed = {directed, make_request(bae_pkg::CMD_FINISH, 1'b0, 16'h0000)};
      foreach (directed[i])
         send_request(directed[i], i >= 12);

      // Random part: mostly encode requests, the odd finish with random ignored fields.
      // Half the bits follow their probability, as a real source would; the rest are random.
      // Hold valid high with no gaps for a stretch in the middle.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         command  = ($urandom_range(0, 99) < 4) ? bae_pkg::CMD_FINISH : bae_pkg::CMD_ENCODE;
         prob_one = pick_probability();
         if ($urandom_range(0, 1))
            bit_value = 17'($urandom_range(0, 65535)) < {1'b0, prob_one};
         else
            bit_value = 1'($urandom_range(0, 1));
         send_request(make_request(command, bit_value, prob_one), !(n >= 100 && n < 140));
      end
      req_valid <= 1'b0;

      // Wait for every owed byte, then idle a while to catch strays
      while (board.pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d finishes) and compared %0d coded bytes,",
               requests_accepted, finishes_accepted, board.bytes_checked);
      $display("with one %0d-cycle output hold-off; %0d mismatches", HOLD_OFF_CYCLES,
               board.failures);
      if (board.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
src/bae_pkg.sv
src/bae_front.sv
src/bae_queue.sv
src/bae_back.sv
src/binary_arithmetic_encoder.sv
bench/testbench.sv
